// File: design/tcle_pkg.sv
// Shared types, constants and the echo expansion function of the tty line editor.
`default_nettype none

package tcle_pkg;

   localparam int CHAR_W    = 8;
   localparam int KIND_W    = 3;
   localparam int FLAG_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int SUB_W     = 3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [SUB_W-1:0]  sub_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO = 3'd0,
      KIND_LINE = 3'd1,
      KIND_INTR = 3'd2,
      KIND_QUIT = 3'd3,
      KIND_EOF  = 3'd4
   } kind_type;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_INTR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KILL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EOF     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REPRINT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAGS   = 3'd6;

   // local flag bit positions
   localparam int FLAG_CANON  = 0;
   localparam int FLAG_SIG    = 1;
   localparam int FLAG_ECHO   = 2;
   localparam int FLAG_ECHONL = 3;

   localparam char_type RST_INTR    = 8'd3;
   localparam char_type RST_QUIT    = 8'd28;
   localparam char_type RST_ERASE   = 8'd8;
   localparam char_type RST_KILL    = 8'd21;
   localparam char_type RST_EOF     = 8'd4;
   localparam char_type RST_REPRINT = 8'd18;
   localparam logic [FLAG_W-1:0] RST_FLAGS = 4'hF;

   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_NL     = 8'h0A;
   localparam char_type CH_BS     = 8'h08;
   localparam char_type CH_SP     = 8'h20;
   localparam char_type CH_CARET  = 8'h5E;
   localparam char_type CH_QMARK  = 8'h3F;
   localparam char_type CH_GT     = 8'h3E;
   localparam char_type CH_DEL    = 8'h7F;
   localparam char_type CARET_OFS = 8'h40;

   localparam sub_type RUB_LAST_CTL = 3'd5;
   localparam sub_type RUB_LAST     = 3'd2;
   localparam sub_type RUB_SPACE    = 3'd1;

   typedef enum logic [1:0] {
      XM_PLAIN  = 2'd0,
      XM_CARET  = 2'd1,
      XM_RUBOUT = 2'd2
   } xmode_type;

   typedef enum logic [2:0] {
      SRC_ZERO = 3'd0,
      SRC_NL   = 3'd1,
      SRC_GT   = 3'd2,
      SRC_SP   = 3'd3,
      SRC_CHAR = 3'd4,
      SRC_MEM  = 3'd5
   } src_type;

   typedef enum logic [1:0] {
      LEN_HOLD  = 2'd0,
      LEN_CLEAR = 2'd1,
      LEN_INC   = 2'd2,
      LEN_DEC   = 2'd3
   } len_op_type;

   typedef enum logic [2:0] {
      WALK_HOLD     = 3'd0,
      WALK_ASC_LINE = 3'd1,
      WALK_ASC_NL   = 3'd2,
      WALK_DESC_ALL = 3'd3,
      WALK_DESC_ONE = 3'd4,
      WALK_UP       = 3'd5,
      WALK_DOWN     = 3'd6
   } walk_op_type;

   typedef struct packed {
      logic        latch_char;
      len_op_type  len_op;
      walk_op_type walk_op;
      logic        mem_we;
      logic        mem_wr_nl;
      logic        mem_re;
      logic        emit;
      kind_type    kind;
      src_type     src;
      xmode_type   xmode;
      logic        last;
      logic        sub_clr;
      logic        sub_inc;
   } tcle_cmd_type;

   typedef struct packed {
      logic canon;
      logic sig;
      logic echo;
      logic echonl;
      logic m_kill;
      logic m_eof;
      logic m_intr;
      logic m_reprint;
      logic m_quit;
      logic m_erase;
      logic is_cr;
      logic is_nl;
      logic len_zero;
      logic len_full;
      logic cnt_zero;
      logic sub_last;
      logic out_free;
   } tcle_status_type;

   typedef struct packed {
      char_type ch;
      logic     last;
   } xout_type;

   // One echo byte of the plain, caret or rubout form of b; sub picks the byte.
   function automatic xout_type expand(char_type b, xmode_type m, sub_type sub);
      xout_type r;
      logic     ctl;
      sub_type  ph;
      ctl    = (b < CH_SP) || (b == CH_DEL);
      ph     = sub;
      r.ch   = b;
      r.last = 1'b1;
      unique case (m)
         XM_CARET: begin
            if (ctl) begin
               if (sub == '0) begin
                  r.ch   = CH_CARET;
                  r.last = 1'b0;
               end else begin
                  r.ch = (b == CH_DEL) ? CH_QMARK : b + CARET_OFS;
               end
            end
         end
         XM_RUBOUT: begin
            // control bytes took two columns: each rubout byte doubled
            if (ctl) begin
               ph     = sub >> 1;
               r.last = (sub == RUB_LAST_CTL);
            end else begin
               r.last = (sub == RUB_LAST);
            end
            r.ch = (ph == RUB_SPACE) ? CH_SP : CH_BS;
         end
         default: begin
            r.ch   = b;
            r.last = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/tcle_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tcle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/tcle_ctrl.sv
// Sequencer of the tty line editor: decodes a request and steps out its results.
`default_nettype none

module tcle_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           busy,
   input  wire tcle_pkg::tcle_status_type status,
   output tcle_pkg::tcle_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EVENT,
      ST_CARET,
      ST_NL,
      ST_GT,
      ST_SP,
      ST_RD,
      ST_EMIT,
      ST_RAW_LINE,
      ST_RAW_ECHO
   } state_type;

   typedef enum logic [2:0] {
      OP_EOF,
      OP_INTR,
      OP_QUIT,
      OP_REPRINT,
      OP_NEWLINE,
      OP_OTHER
   } op_type;

   typedef enum logic [1:0] {
      WK_RUB,
      WK_CARET,
      WK_LINE
   } wk_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   wk_type             wk_ff, wk_in;
   tcle_pkg::kind_type ev_kind;
   logic               op_signal;

   assign busy = (state_ff != ST_IDLE);

   assign ev_kind = (op_ff == OP_INTR) ? tcle_pkg::KIND_INTR :
                    (op_ff == OP_QUIT) ? tcle_pkg::KIND_QUIT : tcle_pkg::KIND_EOF;

   // caret echo of these is closed by a newline
   assign op_signal = (op_ff == OP_EOF) || (op_ff == OP_INTR) || (op_ff == OP_QUIT);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      wk_in    = wk_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_char = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.sub_clr = 1'b1;
            state_in    = ST_IDLE;
            priority if (!status.canon) begin
               state_in = ST_RAW_LINE;
            end else if (status.m_kill) begin
               if (!status.len_zero) begin
                  cmd.len_op = tcle_pkg::LEN_CLEAR;
                  if (status.echo) begin
                     cmd.walk_op = tcle_pkg::WALK_DESC_ALL;
                     wk_in       = WK_RUB;
                     state_in    = ST_RD;
                  end
               end
            end else if (status.m_eof) begin
               op_in    = OP_EOF;
               state_in = ST_EVENT;
            end else if (status.m_intr || (!status.m_reprint && status.m_quit)) begin
               op_in = status.m_intr ? OP_INTR : OP_QUIT;
               if (status.sig) begin
                  cmd.len_op = tcle_pkg::LEN_CLEAR;
                  state_in   = ST_EVENT;
               end else if (status.echo) begin
                  state_in = ST_CARET;
               end
            end else if (status.m_reprint) begin
               if (status.echo) begin
                  op_in    = OP_REPRINT;
                  state_in = ST_NL;
               end
            end else if (status.m_erase) begin
               if (!status.len_zero) begin
                  cmd.len_op = tcle_pkg::LEN_DEC;
                  if (status.echo) begin
                     cmd.walk_op = tcle_pkg::WALK_DESC_ONE;
                     wk_in       = WK_RUB;
                     state_in    = ST_RD;
                  end
               end
            end else if (status.is_cr) begin
               state_in = ST_IDLE;
            end else if (status.is_nl) begin
               cmd.walk_op = tcle_pkg::WALK_ASC_NL;
               cmd.len_op  = tcle_pkg::LEN_CLEAR;
               wk_in       = WK_LINE;
               op_in       = OP_NEWLINE;
               if (!status.len_full) begin
                  cmd.mem_we    = 1'b1;
                  cmd.mem_wr_nl = 1'b1;
               end
               if (!status.len_full && (status.echo || status.echonl)) begin
                  state_in = ST_NL;
               end else begin
                  state_in = ST_RD;
               end
            end else if (!status.len_full) begin
               cmd.mem_we = 1'b1;
               cmd.len_op = tcle_pkg::LEN_INC;
               if (status.echo) begin
                  op_in    = OP_OTHER;
                  state_in = ST_CARET;
               end
            end else begin
               // full line: byte dropped
               state_in = ST_IDLE;
            end
         end
         ST_EVENT: begin
            cmd.emit = 1'b1;
            cmd.kind = ev_kind;
            cmd.src  = tcle_pkg::SRC_ZERO;
            cmd.last = !status.echo;
            if (status.out_free) begin
               state_in = status.echo ? ST_CARET : ST_IDLE;
            end
         end
         ST_CARET: begin
            cmd.emit  = 1'b1;
            cmd.kind  = tcle_pkg::KIND_ECHO;
            cmd.src   = tcle_pkg::SRC_CHAR;
            cmd.xmode = tcle_pkg::XM_CARET;
            cmd.last  = (op_ff == OP_OTHER) && status.sub_last;
            if (status.out_free) begin
               if (status.sub_last) begin
                  cmd.sub_clr = 1'b1;
                  state_in    = (op_ff == OP_OTHER) ? ST_IDLE : ST_NL;
               end else begin
                  cmd.sub_inc = 1'b1;
               end
            end
         end
         ST_NL: begin
            cmd.emit = 1'b1;
            cmd.kind = tcle_pkg::KIND_ECHO;
            cmd.src  = tcle_pkg::SRC_NL;
            cmd.last = op_signal;
            if (status.out_free) begin
               if (op_ff == OP_REPRINT) begin
                  state_in = ST_GT;
               end else if (op_ff == OP_NEWLINE) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_GT: begin
            cmd.emit = 1'b1;
            cmd.kind = tcle_pkg::KIND_ECHO;
            cmd.src  = tcle_pkg::SRC_GT;
            if (status.out_free) begin
               state_in = ST_SP;
            end
         end
         ST_SP: begin
            cmd.emit = 1'b1;
            cmd.kind = tcle_pkg::KIND_ECHO;
            cmd.src  = tcle_pkg::SRC_SP;
            cmd.last = status.len_zero;
            if (status.out_free) begin
               if (status.len_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.walk_op = tcle_pkg::WALK_ASC_LINE;
                  wk_in       = WK_CARET;
                  state_in    = ST_RD;
               end
            end
         end
         ST_RD: begin
            cmd.mem_re = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit  = 1'b1;
            cmd.kind  = (wk_ff == WK_LINE) ? tcle_pkg::KIND_LINE : tcle_pkg::KIND_ECHO;
            cmd.src   = tcle_pkg::SRC_MEM;
            cmd.xmode = (wk_ff == WK_RUB)   ? tcle_pkg::XM_RUBOUT :
                        (wk_ff == WK_CARET) ? tcle_pkg::XM_CARET  : tcle_pkg::XM_PLAIN;
            cmd.last  = status.sub_last && status.cnt_zero;
            if (status.out_free) begin
               if (status.sub_last) begin
                  cmd.sub_clr = 1'b1;
                  if (status.cnt_zero) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.walk_op = (wk_ff == WK_RUB) ? tcle_pkg::WALK_DOWN : tcle_pkg::WALK_UP;
                     state_in    = ST_RD;
                  end
               end else begin
                  cmd.sub_inc = 1'b1;
               end
            end
         end
         ST_RAW_LINE: begin
            cmd.emit  = 1'b1;
            cmd.kind  = tcle_pkg::KIND_LINE;
            cmd.src   = tcle_pkg::SRC_CHAR;
            cmd.xmode = tcle_pkg::XM_PLAIN;
            cmd.last  = !status.echo;
            if (status.out_free) begin
               state_in = status.echo ? ST_RAW_ECHO : ST_IDLE;
            end
         end
         ST_RAW_ECHO: begin
            cmd.emit  = 1'b1;
            cmd.kind  = tcle_pkg::KIND_ECHO;
            cmd.src   = tcle_pkg::SRC_CHAR;
            cmd.xmode = tcle_pkg::XM_PLAIN;
            cmd.last  = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_OTHER;
         wk_ff    <= WK_LINE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         wk_ff    <= wk_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tcle_dp.sv
// Datapath of the tty line editor: control registers, line store, walk counters, result register.
`default_nettype none

module tcle_dp #(
   parameter int LINE_MAX = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [tcle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tcle_pkg::CHAR_W-1:0]         csr_wr_data,
   input  wire logic [tcle_pkg::CHAR_W-1:0]         req_char_in,
   input  wire tcle_pkg::tcle_cmd_type              cmd,
   output tcle_pkg::tcle_status_type                status,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic [tcle_pkg::KIND_W-1:0]              rsp_out_kind,
   output logic [tcle_pkg::CHAR_W-1:0]              rsp_out_byte,
   output logic                                     rsp_out_last
);

   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   tcle_pkg::char_type intr_ff, quit_ff, erase_ff, kill_ff, eof_ff, reprint_ff;
   logic [tcle_pkg::FLAG_W-1:0] flags_ff;

   tcle_pkg::char_type char_ff;
   logic [LEN_W-1:0]   len_ff, len_in, len_m1;
   logic [IDX_W-1:0]   idx_ff, idx_in, cnt_ff, cnt_in;
   tcle_pkg::sub_type  sub_ff, sub_in;
   tcle_pkg::char_type rd_data;
   tcle_pkg::xout_type xo;
   tcle_pkg::char_type tok;
   logic               out_free, load;

   logic               rsp_valid_ff, rsp_valid_in;
   tcle_pkg::kind_type kind_ff;
   tcle_pkg::char_type byte_ff;
   logic               last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         intr_ff    <= tcle_pkg::RST_INTR;
         quit_ff    <= tcle_pkg::RST_QUIT;
         erase_ff   <= tcle_pkg::RST_ERASE;
         kill_ff    <= tcle_pkg::RST_KILL;
         eof_ff     <= tcle_pkg::RST_EOF;
         reprint_ff <= tcle_pkg::RST_REPRINT;
         flags_ff   <= tcle_pkg::RST_FLAGS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcle_pkg::CSR_INTR:    intr_ff    <= csr_wr_data;
            tcle_pkg::CSR_QUIT:    quit_ff    <= csr_wr_data;
            tcle_pkg::CSR_ERASE:   erase_ff   <= csr_wr_data;
            tcle_pkg::CSR_KILL:    kill_ff    <= csr_wr_data;
            tcle_pkg::CSR_EOF:     eof_ff     <= csr_wr_data;
            tcle_pkg::CSR_REPRINT: reprint_ff <= csr_wr_data;
            tcle_pkg::CSR_FLAGS:   flags_ff   <= csr_wr_data[tcle_pkg::FLAG_W-1:0];
            default: ;
         endcase
      end
   end

   assign len_m1 = len_ff - LEN_W'(1);

   always_comb begin
      unique case (cmd.len_op)
         tcle_pkg::LEN_CLEAR: len_in = '0;
         tcle_pkg::LEN_INC:   len_in = len_ff + LEN_W'(1);
         tcle_pkg::LEN_DEC:   len_in = len_m1;
         default:             len_in = len_ff;
      endcase
   end

   // idx is the entry to read next, cnt the entries still to follow it
   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      unique case (cmd.walk_op)
         tcle_pkg::WALK_ASC_LINE: begin
            idx_in = '0;
            cnt_in = len_m1[IDX_W-1:0];
         end
         tcle_pkg::WALK_ASC_NL: begin
            // newline goes in at len unless the line is already full
            idx_in = '0;
            cnt_in = status.len_full ? len_m1[IDX_W-1:0] : len_ff[IDX_W-1:0];
         end
         tcle_pkg::WALK_DESC_ALL: begin
            idx_in = len_m1[IDX_W-1:0];
            cnt_in = len_m1[IDX_W-1:0];
         end
         tcle_pkg::WALK_DESC_ONE: begin
            idx_in = len_m1[IDX_W-1:0];
            cnt_in = '0;
         end
         tcle_pkg::WALK_UP: begin
            idx_in = idx_ff + IDX_W'(1);
            cnt_in = cnt_ff - IDX_W'(1);
         end
         tcle_pkg::WALK_DOWN: begin
            idx_in = idx_ff - IDX_W'(1);
            cnt_in = cnt_ff - IDX_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.sub_clr) begin
         sub_in = '0;
      end else if (cmd.sub_inc) begin
         sub_in = sub_ff + tcle_pkg::SUB_W'(1);
      end else begin
         sub_in = sub_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         sub_ff <= '0;
      end else begin
         len_ff <= len_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_char) begin
         char_ff <= req_char_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
   end

   tcle_ram #(
      .WIDTH (tcle_pkg::CHAR_W),
      .DEPTH (LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_we),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (cmd.mem_wr_nl ? tcle_pkg::CH_NL : char_ff),
      .rd_en   (cmd.mem_re),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign xo = tcle_pkg::expand((cmd.src == tcle_pkg::SRC_MEM) ? rd_data : char_ff,
                                cmd.xmode, sub_ff);

   always_comb begin
      unique case (cmd.src)
         tcle_pkg::SRC_NL:   tok = tcle_pkg::CH_NL;
         tcle_pkg::SRC_GT:   tok = tcle_pkg::CH_GT;
         tcle_pkg::SRC_SP:   tok = tcle_pkg::CH_SP;
         tcle_pkg::SRC_CHAR: tok = xo.ch;
         tcle_pkg::SRC_MEM:  tok = xo.ch;
         default:            tok = '0;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = cmd.emit && out_free;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= cmd.kind;
         byte_ff <= tok;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   always_comb begin
      status.canon     = flags_ff[tcle_pkg::FLAG_CANON];
      status.sig       = flags_ff[tcle_pkg::FLAG_SIG];
      status.echo      = flags_ff[tcle_pkg::FLAG_ECHO];
      status.echonl    = flags_ff[tcle_pkg::FLAG_ECHONL];
      status.m_kill    = (char_ff == kill_ff);
      status.m_eof     = (char_ff == eof_ff);
      status.m_intr    = (char_ff == intr_ff);
      status.m_reprint = (char_ff == reprint_ff);
      status.m_quit    = (char_ff == quit_ff);
      status.m_erase   = (char_ff == erase_ff);
      status.is_cr     = (char_ff == tcle_pkg::CH_CR);
      status.is_nl     = (char_ff == tcle_pkg::CH_NL);
      status.len_zero  = (len_ff == '0);
      status.len_full  = (len_ff == LEN_W'(LINE_MAX));
      status.cnt_zero  = (cnt_ff == '0);
      status.sub_last  = (cmd.src == tcle_pkg::SRC_CHAR || cmd.src == tcle_pkg::SRC_MEM) ?
                         xo.last : 1'b1;
      status.out_free  = out_free;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_MAX))
      else $error("line length past the line size");

   a_walk_down: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_op == tcle_pkg::WALK_DOWN |-> idx_ff != '0)
      else $error("rubout walk stepped below entry zero");

   a_walk_up: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_op == tcle_pkg::WALK_UP |-> idx_ff != IDX_W'(LINE_MAX - 1))
      else $error("forward walk stepped past the last entry");

   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != tcle_pkg::KIND_ECHO && kind_ff != tcle_pkg::KIND_LINE
      |-> byte_ff == '0)
      else $error("event result carries a nonzero byte");

endmodule

`default_nettype wire

// File: design/tty_canonical_line_editor_core.sv
// Top level of the tty canonical line editor.
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall  req_char_in
//  rsp      out        rsp_valid/rsp_stall  rsp_out_kind, rsp_out_byte, rsp_out_last
//  csr      in         csr_wr_en            csr_index, csr_wr_data
//
// A request is accepted, then decoded, then gives one result per cycle while rsp_stall
// is low; every stored line byte walked (kill, erase, reprint, newline) first needs
// a line RAM read. The longest request is a kill of a full line of control bytes.
// Synchronous reset restores the control registers and empties the line; the line
// RAM is not cleared. req_stall is high from accept until the last result of the
// request sits in the result register; rsp_stall holds the sequencer.
`default_nettype none

module tty_canonical_line_editor_core #(
   parameter int LINE_MAX = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [tcle_pkg::CHAR_W-1:0]    req_char_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [tcle_pkg::KIND_W-1:0]         rsp_out_kind,
   output logic [tcle_pkg::CHAR_W-1:0]         rsp_out_byte,
   output logic                                rsp_out_last,
   input  wire logic                           csr_wr_en,
   input  wire logic [tcle_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tcle_pkg::CHAR_W-1:0]    csr_wr_data
);

   tcle_pkg::tcle_cmd_type    cmd;
   tcle_pkg::tcle_status_type status;
   logic                      busy;

   assign req_stall = busy;

   tcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd)
   );

   tcle_dp #(
      .LINE_MAX (LINE_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_char_in  (req_char_in),
      .cmd          (cmd),
      .status       (status),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

// File: sim/tty_canonical_line_editor_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tty canonical line editor core.
module tty_canonical_line_editor_core_tb;

   localparam int LINE_LEN      = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      tcle_pkg::kind_type kind;
      tcle_pkg::char_type value;
      logic               last;
   } edit_out_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   tcle_pkg::char_type             req_char_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   logic [tcle_pkg::KIND_W-1:0]    rsp_out_kind;
   tcle_pkg::char_type             rsp_out_byte;
   logic                           rsp_out_last;
   logic                           csr_wr_en   = 1'b0;
   logic [tcle_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   tcle_pkg::char_type             csr_wr_data = '0;

   // mirrored editor registers and line
   tcle_pkg::char_type          intr_ch    = tcle_pkg::RST_INTR;
   tcle_pkg::char_type          quit_ch    = tcle_pkg::RST_QUIT;
   tcle_pkg::char_type          erase_ch   = tcle_pkg::RST_ERASE;
   tcle_pkg::char_type          kill_ch    = tcle_pkg::RST_KILL;
   tcle_pkg::char_type          eof_ch     = tcle_pkg::RST_EOF;
   tcle_pkg::char_type          reprint_ch = tcle_pkg::RST_REPRINT;
   logic [tcle_pkg::FLAG_W-1:0] lflags     = tcle_pkg::RST_FLAGS;
   tcle_pkg::char_type          line_buf [LINE_LEN];
   int                          line_len   = 0;

   edit_out_type keystroke_out [$];
   edit_out_type editor_out_q [$];
   edit_out_type want_out;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_cnt      = 0;
   int req_cnt       = 0;
   int rsp_cnt       = 0;
   int cfg_cnt       = 0;
   int cycle_cnt     = 0;

   tty_canonical_line_editor_core #(
      .LINE_MAX(LINE_LEN)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_kind(rsp_out_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, editor_out_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_cnt++;
         if (editor_out_q.size() == 0) begin
            fail_cnt++;
            $display("%0t: unexpected result kind %0d byte %02h last %0b, expected none",
                     $time, rsp_out_kind, rsp_out_byte, rsp_out_last);
         end else begin
            want_out = editor_out_q.pop_front();
            if (rsp_out_kind !== want_out.kind || rsp_out_byte !== want_out.value ||
                rsp_out_last !== want_out.last) begin
               fail_cnt++;
               $display({"%0t: mismatch expected kind %0d byte %02h last %0b, ",
                         "actual kind %0d byte %02h last %0b"},
                        $time, want_out.kind, want_out.value, want_out.last,
                        rsp_out_kind, rsp_out_byte, rsp_out_last);
            end
         end
      end
   end

   function automatic void put_out(tcle_pkg::kind_type k, tcle_pkg::char_type v);
      edit_out_type rec;
      rec.kind  = k;
      rec.value = v;
      rec.last  = 1'b0;
      keystroke_out.push_back(rec);
   endfunction

   function automatic void put_caret(tcle_pkg::char_type b);
      if (b < tcle_pkg::CH_SP) begin
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_CARET);
         put_out(tcle_pkg::KIND_ECHO, b + tcle_pkg::CARET_OFS);
      end else if (b == tcle_pkg::CH_DEL) begin
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_CARET);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_QMARK);
      end else begin
         put_out(tcle_pkg::KIND_ECHO, b);
      end
   endfunction

   // control bytes occupied two columns, so each rubout byte is doubled
   function automatic void put_rubout(tcle_pkg::char_type b);
      if (b < tcle_pkg::CH_SP || b == tcle_pkg::CH_DEL) begin
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_SP);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_SP);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
      end else begin
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_SP);
         put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_BS);
      end
   endfunction

   // predicts the results of one typed byte and queues them
   function automatic void apply_keystroke(tcle_pkg::char_type c);
      edit_out_type rec;
      logic         echo_on;
      logic         sig_on;
      int           i;
      keystroke_out.delete();
      echo_on = lflags[tcle_pkg::FLAG_ECHO];
      sig_on  = lflags[tcle_pkg::FLAG_SIG];
      if (!lflags[tcle_pkg::FLAG_CANON]) begin
         put_out(tcle_pkg::KIND_LINE, c);
         if (echo_on) put_out(tcle_pkg::KIND_ECHO, c);
      end else if (c == kill_ch) begin
         while (line_len > 0) begin
            line_len--;
            if (echo_on) put_rubout(line_buf[line_len]);
         end
      end else if (c == eof_ch) begin
         put_out(tcle_pkg::KIND_EOF, '0);
         if (echo_on) begin
            put_caret(c);
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_NL);
         end
      end else if (c == intr_ch) begin
         if (sig_on) begin
            put_out(tcle_pkg::KIND_INTR, '0);
            line_len = 0;
         end
         if (echo_on) begin
            put_caret(c);
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_NL);
         end
      end else if (c == reprint_ch) begin
         if (echo_on) begin
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_NL);
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_GT);
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_SP);
            for (i = 0; i < line_len; i++) put_caret(line_buf[i]);
         end
      end else if (c == quit_ch) begin
         if (sig_on) begin
            put_out(tcle_pkg::KIND_QUIT, '0);
            line_len = 0;
         end
         if (echo_on) begin
            put_caret(c);
            put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_NL);
         end
      end else if (c == erase_ch) begin
         if (line_len > 0) begin
            line_len--;
            if (echo_on) put_rubout(line_buf[line_len]);
         end
      end else if (c == tcle_pkg::CH_CR) begin
         // dropped
      end else if (c == tcle_pkg::CH_NL) begin
         if (line_len < LINE_LEN) begin
            line_buf[line_len] = tcle_pkg::CH_NL;
            line_len++;
            if (echo_on || lflags[tcle_pkg::FLAG_ECHONL]) begin
               put_out(tcle_pkg::KIND_ECHO, tcle_pkg::CH_NL);
            end
         end
         for (i = 0; i < line_len; i++) put_out(tcle_pkg::KIND_LINE, line_buf[i]);
         line_len = 0;
      end else if (line_len < LINE_LEN) begin
         line_buf[line_len] = c;
         line_len++;
         if (echo_on) put_caret(c);
      end
      if (keystroke_out.size() > 0) begin
         rec      = keystroke_out.pop_back();
         rec.last = 1'b1;
         keystroke_out.push_back(rec);
      end
      while (keystroke_out.size() > 0) editor_out_q.push_back(keystroke_out.pop_front());
   endfunction

   // mostly well-formed editing: text, line ends and the configured control bytes
   function automatic tcle_pkg::char_type pick_char();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 40)      return tcle_pkg::char_type'($urandom_range(8'h20, 8'h7E));
      else if (r < 50) return tcle_pkg::char_type'($urandom_range(0, 255));
      else if (r < 60) return tcle_pkg::CH_NL;
      else if (r < 64) return tcle_pkg::CH_CR;
      else if (r < 74) return erase_ch;
      else if (r < 78) return kill_ch;
      else if (r < 83) return reprint_ch;
      else if (r < 87) return eof_ch;
      else if (r < 91) return intr_ch;
      else if (r < 95) return quit_ch;
      else             return tcle_pkg::char_type'($urandom_range(0, 31));
   endfunction

   // called at a falling edge; returns at a falling edge with the request still driven
   task automatic send_char(tcle_pkg::char_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_keystroke(c);
      req_cnt++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (editor_out_q.size() != 0);
   endtask

   task automatic write_reg(logic [tcle_pkg::CSR_IDX_W-1:0] idx, tcle_pkg::char_type data);
      wait_drained();
      // a request with no result may still be in flight
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         tcle_pkg::CSR_INTR:    intr_ch    = data;
         tcle_pkg::CSR_QUIT:    quit_ch    = data;
         tcle_pkg::CSR_ERASE:   erase_ch   = data;
         tcle_pkg::CSR_KILL:    kill_ch    = data;
         tcle_pkg::CSR_EOF:     eof_ch     = data;
         tcle_pkg::CSR_REPRINT: reprint_ch = data;
         tcle_pkg::CSR_FLAGS:   lflags     = data[tcle_pkg::FLAG_W-1:0];
         default: begin
         end
      endcase
      cfg_cnt++;
   endtask

   task automatic program_regs(tcle_pkg::char_type intr, tcle_pkg::char_type quit,
                               tcle_pkg::char_type erase, tcle_pkg::char_type kill,
                               tcle_pkg::char_type eof, tcle_pkg::char_type reprint,
                               logic [tcle_pkg::FLAG_W-1:0] flags);
      write_reg(tcle_pkg::CSR_INTR, intr);
      write_reg(tcle_pkg::CSR_QUIT, quit);
      write_reg(tcle_pkg::CSR_ERASE, erase);
      write_reg(tcle_pkg::CSR_KILL, kill);
      write_reg(tcle_pkg::CSR_EOF, eof);
      write_reg(tcle_pkg::CSR_REPRINT, reprint);
      write_reg(tcle_pkg::CSR_FLAGS, {4'b0000, flags});
   endtask

   // reset settings: empty-line edits, caret forms, full line, events
   task automatic test_directed_editing();
      tcle_pkg::char_type script [25] = '{
         tcle_pkg::RST_ERASE, tcle_pkg::RST_KILL, 8'h61, 8'h00, 8'hFF,
         tcle_pkg::RST_REPRINT, tcle_pkg::RST_ERASE, tcle_pkg::CH_CR, tcle_pkg::CH_NL,
         8'h1F, 8'h80, 8'h20, 8'h7F, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, tcle_pkg::CH_NL,
         8'h01, 8'h7A, tcle_pkg::RST_KILL, tcle_pkg::RST_EOF, tcle_pkg::RST_INTR,
         tcle_pkg::RST_QUIT
      };
      foreach (script[i]) send_char(script[i]);
      wait_drained();
   endtask

   // control bytes overlapping each other and CR/NL, signals off, raw mode
   task automatic test_control_overlap_and_raw();
      program_regs(8'h00, 8'hFF, 8'h7F, 8'hFF, tcle_pkg::CH_NL, tcle_pkg::CH_CR, 4'b0011);
      send_char(8'h78);
      send_char(tcle_pkg::CH_CR);
      send_char(8'h00);
      send_char(8'h79);
      send_char(tcle_pkg::CH_NL);
      send_char(8'hFF);
      write_reg(tcle_pkg::CSR_FLAGS, 8'h07);
      send_char(8'h79);
      send_char(8'h7F);
      send_char(8'h77);
      send_char(tcle_pkg::CH_CR);
      send_char(tcle_pkg::CH_NL);
      send_char(8'h00);
      send_char(8'hFF);
      write_reg(tcle_pkg::CSR_FLAGS, 8'h09);
      send_char(8'h6B);
      send_char(8'h00);
      write_reg(tcle_pkg::CSR_FLAGS, 8'h00);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(tcle_pkg::CH_NL);
      write_reg(tcle_pkg::CSR_FLAGS, 8'h04);
      send_char(8'hA5);
      send_char(8'h5A);
      wait_drained();
   endtask

   task automatic test_random_traffic(int n_items);
      int                 sent;
      tcle_pkg::char_type c;
      sent = 0;
      while (sent < n_items) begin
         c = pick_char();
         // now and then hold the next request until the editor has gone quiet
         if (sent % 16 == 15) wait_drained();
         send_char(c);
         if (c != tcle_pkg::CH_CR) sent++;
      end
      wait_drained();
   endtask

   initial begin
      send_idle_pct = 29;
      recv_idle_pct = 67;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_directed_editing();
      test_random_traffic(22);

      send_idle_pct = 67;
      recv_idle_pct = 29;
      test_control_overlap_and_raw();
      program_regs(8'h00, 8'hFF, 8'h7F, tcle_pkg::RST_KILL, tcle_pkg::RST_EOF,
                   tcle_pkg::RST_REPRINT, 4'b1011);
      test_random_traffic(22);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   4'(2 * $urandom_range(0, 7) + 1));
      test_random_traffic(20);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d typed bytes, checked %0d results, made %0d register writes.",
               req_cnt, rsp_cnt, cfg_cnt);
      $display("Covered line editing, overlapping control bytes, raw mode, three stall mixes.");
      if (fail_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/tcle_pkg.sv
design/tcle_ram.sv
design/tcle_ctrl.sv
design/tcle_dp.sv
design/tty_canonical_line_editor_core.sv
sim/tty_canonical_line_editor_core_tb.sv
